FILE: sv/fsdp_pkg.sv
// ----------------------------------------------------------------------------
// fsdp_pkg
// Shared types, character codes and the decimal place table of the
// format-string decimal printer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsdp_pkg;

	// Character codes
	localparam logic [7:0] END_CHAR   = 8'h00;
	localparam logic [7:0] PCT_CHAR   = 8'h25;	// '%'
	localparam logic [7:0] D_CHAR     = 8'h64;	// 'd'
	localparam logic [7:0] ZERO_CHAR  = 8'h30;	// '0'
	localparam logic [7:0] MINUS_CHAR = 8'h2D;	// '-'

	// Number of decimal places of a 16-bit magnitude
	localparam int unsigned NUM_PLACES = 5;
	localparam logic [2:0]  LAST_PLACE = 3'(NUM_PLACES - 1);

	// Input item
	typedef struct packed {
		logic [7:0]         in_char;
		logic signed [15:0] arg_value;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} out_item_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PCT_CHAR,
		ST_DIGIT
	} state_t;

	// Output byte source
	typedef enum logic [2:0] {
		SEL_CHAR,
		SEL_PCT,
		SEL_ZERO,
		SEL_MINUS,
		SEL_DIGIT
	} sel_t;

	// Controller to datapath
	typedef struct packed {
		logic load;	// capture the accepted item
		logic emit;	// write a byte into the output register
		sel_t sel;
		logic last;
		logic step;	// retire one decimal place
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic is_end;
		logic is_pct;
		logic is_d;
		logic arg_zero;
		logic arg_neg;
		logic digit_nz;
		logic k_last;
	} status_t;

	// Weight of decimal place k, ten-thousands first
	function automatic logic [16:0] place_value(input logic [2:0] k);
		logic [16:0] v;
		case (k)
			3'd0:    v = 17'd10000;
			3'd1:    v = 17'd1000;
			3'd2:    v = 17'd100;
			3'd3:    v = 17'd10;
			default: v = 17'd1;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/format_string_decimal_printer.sv
// ----------------------------------------------------------------------------
// format_string_decimal_printer
// A plain byte, an escape percent or a minus sign is written into the output
// register when its item is accepted; a percent-d then steps through the places.
// Plain characters and lone percents pass at one item per cycle, and a percent-d
// at one decimal place per cycle, while out_ready holds; no new item is taken
// while the character after a percent or a percent-d is still being emitted.
// Reset: arst_n clears the pending percent and the output valid flag, sequencer idles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module format_string_decimal_printer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fsdp_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output fsdp_pkg::out_item_t out_item
);

	fsdp_pkg::cmd_t    cmd;
	fsdp_pkg::status_t status;

	// Sequencer
	fsdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath
	fsdp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

FILE: sv/fsdp_datapath.sv
// ----------------------------------------------------------------------------
// fsdp_datapath
// Item capture, magnitude register, one-digit-per-cycle extraction and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsdp_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  fsdp_pkg::in_item_t  in_item,
	input  fsdp_pkg::cmd_t      cmd,
	output fsdp_pkg::status_t   status,
	output logic                out_valid,
	input  logic                out_ready,
	output fsdp_pkg::out_item_t out_item
);

	logic [7:0]          char_q;
	logic [15:0]         mag_q;
	logic [2:0]          kidx_q;
	logic                out_valid_q;
	fsdp_pkg::out_item_t out_q;

	logic [15:0] arg_bits;
	logic [15:0] mag_in;
	logic [7:0]  char_src;
	logic [16:0] pv;
	logic [16:0] mult_v;
	logic [3:0]  digit;
	logic [15:0] rem;
	logic [7:0]  byte_d;

	// Magnitude of the incoming argument; the most negative value maps to 0x8000
	assign arg_bits = in_item.arg_value;
	assign mag_in   = arg_bits[15] ? (~arg_bits + 16'd1) : arg_bits;
	assign char_src = cmd.load ? in_item.in_char : char_q;

	// Digit of the current place: nine parallel compares, top hit wins
	always_comb begin
		pv     = fsdp_pkg::place_value(kidx_q);
		digit  = 4'd0;
		rem    = mag_q;
		mult_v = 17'd0;
		for (int d = 1; d < 10; d++) begin
			mult_v = 17'(pv * 17'(d));
			if ({1'b0, mag_q} >= mult_v) begin
				digit = 4'(d);
				rem   = 16'({1'b0, mag_q} - mult_v);
			end
		end
	end

	// Status toward the controller
	always_comb begin
		status.out_free = !out_valid_q || out_ready;
		status.is_end   = (in_item.in_char == fsdp_pkg::END_CHAR);
		status.is_pct   = (in_item.in_char == fsdp_pkg::PCT_CHAR);
		status.is_d     = (in_item.in_char == fsdp_pkg::D_CHAR);
		status.arg_zero = (arg_bits == 16'd0);
		status.arg_neg  = arg_bits[15];
		status.digit_nz = (digit != 4'd0);
		status.k_last   = (kidx_q == fsdp_pkg::LAST_PLACE);
	end

	// Output byte select
	always_comb begin
		case (cmd.sel)
			fsdp_pkg::SEL_CHAR:  byte_d = char_src;
			fsdp_pkg::SEL_PCT:   byte_d = fsdp_pkg::PCT_CHAR;
			fsdp_pkg::SEL_ZERO:  byte_d = fsdp_pkg::ZERO_CHAR;
			fsdp_pkg::SEL_MINUS: byte_d = fsdp_pkg::MINUS_CHAR;
			fsdp_pkg::SEL_DIGIT: byte_d = fsdp_pkg::ZERO_CHAR + {4'd0, digit};
			default:             byte_d = char_src;
		endcase
	end

	// Captured item and digit state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= in_item.in_char;
			mag_q  <= mag_in;
		end else if (cmd.step) begin
			mag_q  <= rem;
		end
		if (cmd.emit) begin
			out_q.out_char <= byte_d;
			out_q.last     <= cmd.last;
		end
	end

	// Place counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kidx_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				kidx_q <= 3'd0;
			else if (cmd.step)
				kidx_q <= kidx_q + 3'd1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: sv/fsdp_ctrl.sv
// ----------------------------------------------------------------------------
// fsdp_ctrl
// Sequencer: pending-percent state, character decode and digit pacing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsdp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fsdp_pkg::status_t status,
	output fsdp_pkg::cmd_t    cmd
);

	fsdp_pkg::state_t state_q, state_d;
	logic             after_pct_q, after_pct_d;
	logic             started_q, started_d;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsdp_pkg::ST_IDLE;
			after_pct_q <= 1'b0;
			started_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			after_pct_q <= after_pct_d;
			started_q   <= started_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		after_pct_d = after_pct_q;
		started_d   = started_q;
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.emit    = 1'b0;
		cmd.sel     = fsdp_pkg::SEL_CHAR;
		cmd.last    = 1'b0;
		cmd.step    = 1'b0;
		case (state_q)
			fsdp_pkg::ST_IDLE: begin
				in_ready = status.out_free;
				if (in_valid && status.out_free) begin
					cmd.load = 1'b1;
					if (!after_pct_q) begin
						if (status.is_pct) begin
							after_pct_d = 1'b1;
						end else if (!status.is_end) begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
						end
					end else begin
						after_pct_d = 1'b0;
						if (status.is_end) begin
							// lone percent at end of string
							cmd.emit = 1'b1;
							cmd.sel  = fsdp_pkg::SEL_PCT;
							cmd.last = 1'b1;
						end else if (!status.is_d) begin
							cmd.emit = 1'b1;
							cmd.sel  = fsdp_pkg::SEL_PCT;
							state_d  = fsdp_pkg::ST_PCT_CHAR;
						end else if (status.arg_zero) begin
							cmd.emit = 1'b1;
							cmd.sel  = fsdp_pkg::SEL_ZERO;
							cmd.last = 1'b1;
						end else begin
							if (status.arg_neg) begin
								cmd.emit = 1'b1;
								cmd.sel  = fsdp_pkg::SEL_MINUS;
							end
							started_d = 1'b0;
							state_d   = fsdp_pkg::ST_DIGIT;
						end
					end
				end
			end
			fsdp_pkg::ST_PCT_CHAR: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = fsdp_pkg::SEL_CHAR;
					cmd.last = 1'b1;
					state_d  = fsdp_pkg::ST_IDLE;
				end
			end
			fsdp_pkg::ST_DIGIT: begin
				// one place per cycle while the output register is free, leading zeros dropped
				if (status.out_free) begin
					cmd.step = 1'b1;
					if (status.digit_nz || started_q) begin
						cmd.emit  = 1'b1;
						cmd.sel   = fsdp_pkg::SEL_DIGIT;
						cmd.last  = status.k_last;
						started_d = 1'b1;
					end
					if (status.k_last)
						state_d = fsdp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fsdp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/fsdp_checker.sv
// ----------------------------------------------------------------------------
// fsdp_checker
// Port-level checks of the format-string decimal printer, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsdp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input fsdp_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_ready,
	input fsdp_pkg::out_item_t out_item
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled output item changed");

	// No new item while a result is stuck in the output register
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input ready while output stalled");

	// End code gives nothing or a lone percent marked last
	a_end_code: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_item.in_char == fsdp_pkg::END_CHAR) |=>
		!out_valid || ((out_item.out_char == fsdp_pkg::PCT_CHAR) && out_item.last))
		else $error("bad output after end code");

	// Bytes before the last of an item are percent, minus or digits
	a_nonlast_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last |->
		(out_item.out_char == fsdp_pkg::PCT_CHAR) ||
		(out_item.out_char == fsdp_pkg::MINUS_CHAR) ||
		((out_item.out_char >= 8'h30) && (out_item.out_char <= 8'h39)))
		else $error("unexpected non-last byte");

endmodule

bind format_string_decimal_printer fsdp_checker u_fsdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

FILE: tb/fsdp_byte_checker.sv
// ----------------------------------------------------------------------------
// fsdp_byte_checker
// Watches both channels of the format-string decimal printer. Every accepted
// format character is run through a local formatter that tracks the pending
// percent and expands percent-d into decimal bytes. Each byte that leaves the
// block is compared with the oldest predicted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsdp_byte_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  fsdp_pkg::in_item_t  in_item,
	input  logic                out_valid,
	input  logic                out_ready,
	input  fsdp_pkg::out_item_t out_item,
	output int unsigned         fail_count,
	output int unsigned         bytes_due
);
	import fsdp_pkg::*;

	// Bytes the block still owes, oldest first
	out_item_t owed_bytes[$];
	// Local copy of the pending-percent flag
	logic      pct_seen;

	initial begin
		fail_count = 0;
		bytes_due  = 0;
		pct_seen   = 1'b0;
	end

	function automatic void owe_byte(input logic [7:0] c);
		out_item_t b;
		b.out_char = c;
		b.last     = 1'b0;
		owed_bytes.push_back(b);
	endfunction

	// Decimal text of a signed 16-bit argument, leading zeros dropped
	function automatic void owe_decimal(input logic signed [15:0] arg);
		int  mag;
		int  weight;
		int  digit;
		bit  started;
		mag     = arg;
		weight  = 10000;
		started = 1'b0;
		if (mag == 0) begin
			owe_byte(ZERO_CHAR);
			return;
		end
		if (mag < 0) begin
			owe_byte(MINUS_CHAR);
			mag = -mag;
		end
		while (weight > 0) begin
			digit = mag / weight;
			mag   = mag % weight;
			if (digit != 0)
				started = 1'b1;
			if (started)
				owe_byte(ZERO_CHAR + 8'(digit));
			weight = weight / 10;
		end
	endfunction

	// Bytes caused by one format character
	function automatic void format_char(input in_item_t item);
		int first;
		first = owed_bytes.size();
		if (!pct_seen) begin
			if (item.in_char == PCT_CHAR)
				pct_seen = 1'b1;
			else if (item.in_char != END_CHAR)
				owe_byte(item.in_char);
		end else begin
			pct_seen = 1'b0;
			if (item.in_char == END_CHAR) begin
				owe_byte(PCT_CHAR);
			end else if (item.in_char != D_CHAR) begin
				owe_byte(PCT_CHAR);
				owe_byte(item.in_char);
			end else begin
				owe_decimal(item.arg_value);
			end
		end
		if (owed_bytes.size() > first)
			owed_bytes[owed_bytes.size() - 1].last = 1'b1;
	endfunction

	// Compare leaving bytes, then predict from the entering item
	always @(posedge clk) begin
		out_item_t   want;
		int unsigned errs;
		errs = 0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (owed_bytes.size() == 0) begin
					$error("unexpected byte %h (last %b)", out_item.out_char, out_item.last);
					errs += 1;
				end else begin
					want = owed_bytes.pop_front();
					if (want.out_char !== out_item.out_char) begin
						$error("out_char: expected %h, got %h", want.out_char,
							out_item.out_char);
						errs += 1;
					end
					if (want.last !== out_item.last) begin
						$error("last: expected %b, got %b", want.last, out_item.last);
						errs += 1;
					end
				end
			end
			if (in_valid && in_ready)
				format_char(in_item);
		end
		if (errs != 0)
			fail_count <= fail_count + errs;
		bytes_due = owed_bytes.size();
	end

endmodule

FILE: tb/format_string_decimal_printer_test.sv
// ----------------------------------------------------------------------------
// format_string_decimal_printer_test
// Feeds format strings to the printer: a directed set covering plain bytes,
// end codes, percent escapes and percent-d at the argument extremes, then
// random strings of mostly plain bytes. Both handshakes stall at random
// outside one calm stretch. The checker predicts every byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module format_string_decimal_printer_test;
	import fsdp_pkg::*;

	// Kinds of random string fragments
	typedef enum int {
		FRAG_PLAIN,
		FRAG_NUMBER,
		FRAG_ESCAPE,
		FRAG_END,
		FRAG_NOISE
	} frag_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	int unsigned fail_count;
	int unsigned bytes_due;
	bit          calm = 1'b0;

	format_string_decimal_printer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	fsdp_byte_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.fail_count (fail_count),
		.bytes_due  (bytes_due)
	);

	always #10 clk = ~clk;

	// Receiver back-pressure
	always @(negedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);

	// Hands one format character to the block; entered and left at a falling edge
	task automatic send_char(input logic [7:0] c, input logic signed [15:0] arg);
		if (!calm) begin
			while ($urandom_range(99) < 16) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid          <= 1'b1;
		in_item.in_char   <= c;
		in_item.arg_value <= arg;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] random_arg();
		if ($urandom_range(3) == 0)
			return $urandom_range(1) ? -16'($urandom_range(20)) : 16'($urandom_range(20));
		return 16'($urandom);
	endfunction

	initial begin
		frag_t       frag;
		logic [7:0]  c;
		int unsigned sent;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: plain bytes, end codes, escapes, number extremes
		send_char(8'h41, 16'sh7FFF);
		send_char(END_CHAR, 16'sh1234);
		send_char(8'hFF, -16'sd1);
		send_char(8'h80, 16'sd0);
		send_char(PCT_CHAR, 16'sd5);
		send_char(D_CHAR, 16'sd0);
		send_char(PCT_CHAR, 16'sd0);
		send_char(D_CHAR, 16'sd32767);
		send_char(PCT_CHAR, 16'sd0);
		send_char(D_CHAR, -16'sd32768);
		send_char(PCT_CHAR, 16'sd0);
		send_char(D_CHAR, -16'sd1);
		send_char(PCT_CHAR, 16'sd0);
		send_char(D_CHAR, 16'sd10000);
		send_char(PCT_CHAR, 16'sd0);
		send_char(D_CHAR, -16'sd10000);
		send_char(PCT_CHAR, 16'sd0);
		send_char(PCT_CHAR, 16'sd0);
		send_char(PCT_CHAR, 16'sd0);
		send_char(END_CHAR, 16'sd0);
		send_char(PCT_CHAR, 16'sd0);
		send_char(8'h78, 16'sd7);
		send_char(PCT_CHAR, 16'sd0);
		send_char(8'hFF, 16'sd0);
		send_char(D_CHAR, 16'sd99);

		// Random strings, with a calm stretch in the middle
		sent = 0;
		while (sent < 125) begin
			calm = (sent >= 40 && sent < 80);
			frag = frag_t'($urandom_range(9) < 4 ? FRAG_PLAIN : $urandom_range(4));
			case (frag)
				FRAG_PLAIN: begin
					c = 8'($urandom_range(1, 255));
					if (c == PCT_CHAR)
						c = 8'h2E;
					send_char(c, random_arg());
					sent += 1;
				end
				FRAG_NUMBER: begin
					send_char(PCT_CHAR, random_arg());
					send_char(D_CHAR, random_arg());
					sent += 2;
				end
				FRAG_ESCAPE: begin
					send_char(PCT_CHAR, random_arg());
					send_char(8'($urandom_range(255)), random_arg());
					sent += 2;
				end
				FRAG_END: begin
					send_char(END_CHAR, random_arg());
					sent += 1;
				end
				default: begin
					send_char(8'($urandom), 16'($urandom));
					sent += 1;
				end
			endcase
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// Drain, then watch for stray bytes
		while (bytes_due != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("format_string_decimal_printer_test: clean");
		else
			$display("format_string_decimal_printer_test: errors");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("format_string_decimal_printer_test: errors");
		$finish;
	end

endmodule
